>>> hdl/nbmf_pkg.sv
package nbmf_pkg;

   // defaults of the top-level parameters
   localparam int DEF_MAX_COLUMNS = 2048;
   localparam int DEF_MAX_ROWS    = 4096;
   localparam int DEF_MAX_RADIUS  = 7;
   localparam int DEF_SAMPLE_BITS = 32;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int ROW_OUT_W = 12;
   localparam int COL_OUT_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLUMNS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NODATA_VALUE  = 2'd3;

   // reset values
   localparam int RST_RADIUS  = 1;
   localparam int RST_COLUMNS = 2048;
   localparam int RST_ROWS    = 4096;
   localparam logic [CSR_DATA_W-1:0] RST_NODATA = 32'hD8F1_0000;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

endpackage

>>> hdl/nbmf_line_mem.sv
module nbmf_line_mem #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/nbmf_divider.sv
module nbmf_divider #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output logic                    done,
   output logic signed [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]    rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      rem_sh  = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> hdl/nodata_aware_box_mean_filter.sv
// Nodata-aware box mean filter over a raster streamed in row-major order.
// req channel: one item per cell (kind 0, sample) or a drain tick (kind 1).
// rsp channel: at most one filtered cell per item, in raster order, trailing
// the input by window_radius rows and columns; drain ticks flush the tail.
// csr port: single-cycle writes; the user must write only while the block is
// idle (not enforced by the block); any write restarts the frame counters.
// One item is processed at a time. States per item, accepted to result:
//   no result released: CHECK, back to IDLE
//   centre cell is nodata: CHECK, CENTRE, OUT
//   valid centre: CHECK, CENTRE, SWEEP over W cells of the clipped window
//   (up to (2*MAX_RADIUS+1)^2), one cell a cycle via the single read port of
//   the line memory, TAIL, DSTART, DIV (bit-serial, SUM_W = 40 default), OUT.
// A new item is taken while the previous result waits in the rsp register;
// if the receiver stalls, the next result holds the block until it drains.
// Reset is synchronous: state, configuration, frame counters and rsp_valid
// reset; the line memory is not cleared, cells are always written before read.
module nodata_aware_box_mean_filter #(
   parameter int MAX_COLUMNS = nbmf_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = nbmf_pkg::DEF_MAX_ROWS,
   parameter int MAX_RADIUS  = nbmf_pkg::DEF_MAX_RADIUS,
   parameter int SAMPLE_BITS = nbmf_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic signed [nbmf_pkg::VALUE_W-1:0]    req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [nbmf_pkg::VALUE_W-1:0]    rsp_mean_value,
   output logic                                   rsp_is_nodata,
   output logic [nbmf_pkg::ROW_OUT_W-1:0]         rsp_row,
   output logic [nbmf_pkg::COL_OUT_W-1:0]         rsp_column,
   output logic                                   rsp_last_of_frame,
   input  logic                                   csr_wr_en,
   input  logic [nbmf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [nbmf_pkg::CSR_DATA_W-1:0]        csr_wr_data
);
   import nbmf_pkg::*;

   localparam int LINES   = 2 * MAX_RADIUS + 2;
   localparam int LINE_W  = $clog2(LINES);
   localparam int DEPTH   = LINES * MAX_COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W   = $clog2(MAX_ROWS + 1);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int SUM_W   = SAMPLE_BITS + CNT_W;
   localparam int RST_COLS_EFF = (RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RST_COLUMNS;
   localparam int RST_ROWS_EFF = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_CENTRE = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_TAIL   = 3'd4;
   localparam logic [2:0] S_DSTART = 3'd5;
   localparam logic [2:0] S_DIV    = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] line,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(line) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
   endfunction

   function automatic logic [LINE_W-1:0] line_next(input logic [LINE_W-1:0] line);
      return (int'(line) == LINES - 1) ? '0 : line + 1'b1;
   endfunction

   // configuration, held clamped
   logic [RAD_W-1:0]       rad_ff;
   logic [COL_W-1:0]       cols_ff;
   logic [ROW_W-1:0]       rows_ff;
   logic [SAMPLE_BITS-1:0] nd_ff;

   logic [2:0]  state_ff;
   logic [ROW_W-1:0]  in_row_ff, out_row_ff;
   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [LINE_W-1:0] in_line_ff, out_line_ff;
   logic              in_done_ff;

   // window sweep
   logic [ROW_W-1:0]  cur_r_ff, r1_ff;
   logic [COL_W-1:0]  cur_c_ff, c0_ff, c1_ff;
   logic [LINE_W-1:0] cur_line_ff;
   logic              rd_pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic signed [SAMPLE_BITS-1:0] res_ff;
   logic              res_nd_ff;

   logic                          rsp_valid_ff;
   logic signed [VALUE_W-1:0]     rsp_mean_ff;
   logic                          rsp_nd_ff;
   logic [ROW_OUT_W-1:0]          rsp_row_ff;
   logic [COL_OUT_W-1:0]          rsp_col_ff;
   logic                          rsp_last_ff;

   logic                          accept;
   logic                          wr_en, rd_en;
   logic [ADDR_W-1:0]             wr_addr, rd_addr;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] rd_s;
   logic                          acc_hit;
   logic                          div_start, div_done;
   logic signed [SUM_W-1:0]       div_q;

   logic [ROW_W:0]    need_r_w, r0_w;
   logic [COL_W:0]    need_c_w, c0_w;
   logic [ROW_W-1:0]  need_r, r0, rows_m1;
   logic [COL_W-1:0]  need_c, c0, cols_m1;
   logic              cell_ready;
   logic [LINE_W:0]   dr, start_line_w;
   logic              last_cell;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rows_m1   = rows_ff - 1'b1;
   assign cols_m1   = cols_ff - 1'b1;

   // readiness of the next output cell and its window bounds
   always_comb begin
      need_r_w = {1'b0, out_row_ff} + (ROW_W + 1)'(rad_ff);
      need_c_w = {1'b0, out_col_ff} + (COL_W + 1)'(rad_ff);
      need_r   = (need_r_w > {1'b0, rows_m1}) ? rows_m1 : need_r_w[ROW_W-1:0];
      need_c   = (need_c_w > {1'b0, cols_m1}) ? cols_m1 : need_c_w[COL_W-1:0];
      r0_w     = {1'b0, out_row_ff} - (ROW_W + 1)'(rad_ff);
      c0_w     = {1'b0, out_col_ff} - (COL_W + 1)'(rad_ff);
      r0       = r0_w[ROW_W] ? '0 : r0_w[ROW_W-1:0];
      c0       = c0_w[COL_W] ? '0 : c0_w[COL_W-1:0];
      cell_ready = in_done_ff || (in_row_ff > need_r) ||
                   (in_row_ff == need_r && in_col_ff > need_c);
      dr = (LINE_W + 1)'(out_row_ff - r0);
      start_line_w = ({1'b0, out_line_ff} >= dr) ? {1'b0, out_line_ff} - dr
                                                 : {1'b0, out_line_ff} + (LINE_W + 1)'(LINES) - dr;
      last_cell = (out_row_ff == rows_m1) && (out_col_ff == cols_m1);
   end

   assign wr_en   = accept && req_kind == KIND_SAMPLE && !in_done_ff;
   assign wr_addr = cell_addr(in_line_ff, in_col_ff);
   assign rd_en   = (state_ff == S_CHECK) || (state_ff == S_SWEEP);
   assign rd_addr = (state_ff == S_CHECK) ? cell_addr(out_line_ff, out_col_ff)
                                          : cell_addr(cur_line_ff, cur_c_ff);
   assign rd_s    = $signed(rd_data);
   assign acc_hit = rd_pend_ff && (rd_data != nd_ff);
   assign div_start = (state_ff == S_DSTART);

   nbmf_line_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample[SAMPLE_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nbmf_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rad_ff       <= RAD_W'(RST_RADIUS);
         cols_ff      <= COL_W'(RST_COLS_EFF);
         rows_ff      <= ROW_W'(RST_ROWS_EFF);
         nd_ff        <= RST_NODATA[SAMPLE_BITS-1:0];
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_line_ff   <= '0;
         in_done_ff   <= 1'b0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_line_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WINDOW_RADIUS: begin
                  if (csr_wr_data[2:0] == 3'd0) begin
                     rad_ff <= RAD_W'(1);
                  end else if (int'(csr_wr_data[2:0]) > MAX_RADIUS) begin
                     rad_ff <= RAD_W'(MAX_RADIUS);
                  end else begin
                     rad_ff <= RAD_W'(csr_wr_data[2:0]);
                  end
               end
               CSR_FRAME_COLUMNS: begin
                  if (csr_wr_data[11:0] == 12'd0) begin
                     cols_ff <= COL_W'(1);
                  end else if (int'(csr_wr_data[11:0]) > MAX_COLUMNS) begin
                     cols_ff <= COL_W'(MAX_COLUMNS);
                  end else begin
                     cols_ff <= COL_W'(csr_wr_data[11:0]);
                  end
               end
               CSR_FRAME_ROWS: begin
                  if (csr_wr_data[12:0] == 13'd0) begin
                     rows_ff <= ROW_W'(1);
                  end else if (int'(csr_wr_data[12:0]) > MAX_ROWS) begin
                     rows_ff <= ROW_W'(MAX_ROWS);
                  end else begin
                     rows_ff <= ROW_W'(csr_wr_data[12:0]);
                  end
               end
               CSR_NODATA_VALUE: begin
                  nd_ff <= csr_wr_data[SAMPLE_BITS-1:0];
               end
               default: begin
               end
            endcase
            in_row_ff   <= '0;
            in_col_ff   <= '0;
            in_line_ff  <= '0;
            in_done_ff  <= 1'b0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_line_ff <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (wr_en) begin
                     if (in_col_ff + 1'b1 >= cols_ff) begin
                        in_col_ff  <= '0;
                        in_row_ff  <= in_row_ff + 1'b1;
                        in_line_ff <= line_next(in_line_ff);
                        if (in_row_ff + 1'b1 >= rows_ff) begin
                           in_done_ff <= 1'b1;
                        end
                     end else begin
                        in_col_ff <= in_col_ff + 1'b1;
                     end
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // centre read issued here
               cur_r_ff    <= r0;
               cur_c_ff    <= c0;
               c0_ff       <= c0;
               c1_ff       <= need_c;
               r1_ff       <= need_r;
               cur_line_ff <= start_line_w[LINE_W-1:0];
               state_ff    <= cell_ready ? S_CENTRE : S_IDLE;
            end
            S_CENTRE: begin
               if (rd_data == nd_ff) begin
                  res_ff    <= $signed(nd_ff);
                  res_nd_ff <= 1'b1;
                  state_ff  <= S_OUT;
               end else begin
                  sum_ff     <= '0;
                  cnt_ff     <= '0;
                  rd_pend_ff <= 1'b0;
                  state_ff   <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               rd_pend_ff <= 1'b1;
               if (acc_hit) begin
                  sum_ff <= sum_ff + SUM_W'(rd_s);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (cur_c_ff == c1_ff) begin
                  cur_c_ff    <= c0_ff;
                  cur_r_ff    <= cur_r_ff + 1'b1;
                  cur_line_ff <= line_next(cur_line_ff);
                  if (cur_r_ff == r1_ff) begin
                     state_ff <= S_TAIL;
                  end
               end else begin
                  cur_c_ff <= cur_c_ff + 1'b1;
               end
            end
            S_TAIL: begin
               if (acc_hit) begin
                  sum_ff <= sum_ff + SUM_W'(rd_s);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               rd_pend_ff <= 1'b0;
               state_ff   <= S_DSTART;
            end
            S_DSTART: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  res_ff    <= div_q[SAMPLE_BITS-1:0];
                  res_nd_ff <= 1'b0;
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mean_ff  <= VALUE_W'(res_ff);
                  rsp_nd_ff    <= res_nd_ff;
                  rsp_row_ff   <= ROW_OUT_W'(out_row_ff);
                  rsp_col_ff   <= COL_OUT_W'(out_col_ff);
                  rsp_last_ff  <= last_cell;
                  if (last_cell) begin
                     in_row_ff   <= '0;
                     in_col_ff   <= '0;
                     in_line_ff  <= '0;
                     in_done_ff  <= 1'b0;
                     out_row_ff  <= '0;
                     out_col_ff  <= '0;
                     out_line_ff <= '0;
                  end else if (out_col_ff == cols_m1) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + 1'b1;
                     out_line_ff <= line_next(out_line_ff);
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_value    = rsp_mean_ff;
   assign rsp_is_nodata     = rsp_nd_ff;
   assign rsp_row           = rsp_row_ff;
   assign rsp_column        = rsp_col_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("item shown outside the output step");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff != '0 && int'(cnt_ff) <= WIN_MAX))
      else $error("window count out of range at divide");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && state_ff == S_IDLE))
      else $error("block busy right after reset");
`endif

endmodule
